// File: src/drle_pkg.sv
package drle_pkg;

    // line and counter limits
    localparam int LINE_BYTES = 65536;
    localparam int RUN_W      = 17;
    localparam int LEN_W      = 17;
    localparam logic [LEN_W-1:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [LEN_W-1:0] HDR_BYTES = 17'd4;

    // code group and packer sizes
    localparam int SEG_W        = 51;
    localparam int SEG_LEN_W    = 6;
    localparam int BUF_W        = 64;
    localparam int BUF_CNT_W    = 7;
    localparam int BUF_FILL_MAX = 7 + SEG_W;

    // queue between classifier and packer
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // code words
    localparam logic [8:0] NONE_MARK  = 9'h100;
    localparam logic [3:0] ESC_LIT    = 4'b1110;
    localparam logic [3:0] ESC_RUN    = 4'b1111;
    localparam logic [2:0] LONG_LIT   = 3'b111;
    localparam logic [2:0] ZERO_DELTA = 3'b011;
    localparam logic [7:0] LEN_ESC    = 8'hFF;
    localparam int DELTA_MAX = 3;
    localparam int RUN_LONG  = 4;
    localparam int RUN_MID   = 19;
    localparam int RUN_HUGE  = 274;

    // one code group, right-aligned bits
    typedef struct packed {
        logic [SEG_W-1:0]     bits;
        logic [SEG_LEN_W-1:0] len;
        logic                 last;
    } t_seg;

    // codes one finished run; last is left clear
    function automatic t_seg code_run(input logic [7:0] cur, input logic [8:0] prev,
                                      input logic [RUN_W-1:0] run);
        logic signed [9:0]    d;
        logic                 small_d;
        logic [2:0]           dcode;
        logic [SEG_W-1:0]     vbits;
        logic [SEG_LEN_W-1:0] vlen;
        logic [SEG_W-1:0]     pbits;
        logic [SEG_LEN_W-1:0] plen;
        logic [RUN_W-1:0]     rl4;
        logic [RUN_W-1:0]     rl19;
        logic [23:0]          n;
        logic [1:0]           reps;
        t_seg                 s;
        d       = $signed({2'b00, cur}) - $signed({2'b00, prev[7:0]});
        small_d = !prev[8] && (d >= -10'(DELTA_MAX)) && (d <= 10'(DELTA_MAX));
        dcode   = 3'(d + 10'(DELTA_MAX));
        rl4     = run - RUN_W'(RUN_LONG);
        rl19    = run - RUN_W'(RUN_MID);
        n       = {7'd0, run} - 24'(RUN_LONG);
        reps    = run[1:0] - 2'd1;
        s.last  = 1'b0;
        if (run < RUN_W'(RUN_LONG)) begin
            if (small_d) begin
                vbits = SEG_W'(dcode);
                vlen  = SEG_LEN_W'(3);
            end else begin
                vbits = SEG_W'({ESC_LIT, cur});
                vlen  = SEG_LEN_W'(12);
            end
            pbits = '0;
            plen  = '0;
            // short runs repeat the zero-delta code
            case (reps)
                2'd1: begin
                    s.bits = (vbits << 3) | SEG_W'(ZERO_DELTA);
                    s.len  = vlen + SEG_LEN_W'(3);
                end
                2'd2: begin
                    s.bits = (vbits << 6) | SEG_W'({ZERO_DELTA, ZERO_DELTA});
                    s.len  = vlen + SEG_LEN_W'(6);
                end
                default: begin
                    s.bits = vbits;
                    s.len  = vlen;
                end
            endcase
        end else begin
            if (small_d) begin
                vbits = SEG_W'(dcode);
                vlen  = SEG_LEN_W'(3);
            end else begin
                vbits = SEG_W'({LONG_LIT, cur});
                vlen  = SEG_LEN_W'(11);
            end
            if (run < RUN_W'(RUN_MID)) begin
                pbits = SEG_W'({ESC_RUN, rl4[3:0]});
                plen  = SEG_LEN_W'(8);
            end else if (run < RUN_W'(RUN_HUGE)) begin
                pbits = SEG_W'({ESC_RUN, ESC_RUN, rl19[7:0]});
                plen  = SEG_LEN_W'(16);
            end else begin
                // 24-bit length, low byte first
                pbits = SEG_W'({ESC_RUN, ESC_RUN, LEN_ESC, n[7:0], n[15:8], n[23:16]});
                plen  = SEG_LEN_W'(40);
            end
            s.bits = (pbits << vlen) | vbits;
            s.len  = plen + vlen;
        end
        return s;
    endfunction

endpackage

// File: src/drle_fifo.sv
module drle_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  drle_pkg::t_seg  i_push_seg,
    output logic            o_full,
    output logic            o_valid,
    output drle_pkg::t_seg  o_seg,
    input  logic            i_pop
);

    drle_pkg::t_seg                  r_mem [drle_pkg::Q_DEPTH];
    logic [drle_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [drle_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [drle_pkg::Q_CNT_W-1:0]    r_count;
    logic [drle_pkg::Q_CNT_W-1:0]    n_count;

    assign o_full  = (r_count == drle_pkg::Q_CNT_W'(drle_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_seg   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_seg;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("code group pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("code group popped from an empty queue");

endmodule

// File: src/drle_front.sv
module drle_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_sample,
    input  logic            i_last,
    output logic            o_push,
    output drle_pkg::t_seg  o_seg,
    input  logic            i_full
);

    logic [7:0]                  r_cur;
    logic [8:0]                  r_prev;
    logic [drle_pkg::RUN_W-1:0]  r_run;
    logic                        r_line_start;
    logic                        r_tail;
    logic [7:0]                  n_cur;
    logic [8:0]                  n_prev;
    logic [drle_pkg::RUN_W-1:0]  n_run;
    logic                        n_line_start;
    logic                        n_tail;

    logic [7:0]                  e_cur;
    logic [8:0]                  e_prev;
    logic [drle_pkg::RUN_W-1:0]  e_run;
    logic [drle_pkg::RUN_W-1:0]  run_inc;
    logic                        same;
    logic                        accept;
    logic [7:0]                  f_cur;
    logic [8:0]                  f_prev;
    logic [drle_pkg::RUN_W-1:0]  f_run;
    drle_pkg::t_seg              seg;

    // a new line starts from the sample itself with no reference value
    assign e_cur   = r_line_start ? i_sample : r_cur;
    assign e_prev  = r_line_start ? drle_pkg::NONE_MARK : r_prev;
    assign e_run   = r_line_start ? '0 : r_run;
    assign same    = (i_sample == e_cur);
    assign run_inc = (e_run < drle_pkg::RUN_W'(drle_pkg::LINE_BYTES)) ? e_run + 1'b1 : e_run;

    assign o_ready = !r_tail && !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (r_tail) begin
            f_cur  = r_cur;
            f_prev = r_prev;
            f_run  = r_run;
        end else if (same) begin
            f_cur  = e_cur;
            f_prev = e_prev;
            f_run  = run_inc;
        end else begin
            f_cur  = e_cur;
            f_prev = e_prev;
            f_run  = e_run;
        end
        seg      = drle_pkg::code_run(f_cur, f_prev, f_run);
        seg.last = r_tail || (same && i_last);
    end

    assign o_seg  = seg;
    assign o_push = r_tail ? !i_full : (accept && (!same || i_last));

    always_comb begin
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_run        = r_run;
        n_line_start = r_line_start;
        n_tail       = r_tail;
        if (r_tail) begin
            // single-sample run closing the line
            if (!i_full) begin
                n_cur        = '0;
                n_prev       = drle_pkg::NONE_MARK;
                n_run        = '0;
                n_line_start = 1'b1;
                n_tail       = 1'b0;
            end
        end else if (accept) begin
            if (same && i_last) begin
                n_cur        = '0;
                n_prev       = drle_pkg::NONE_MARK;
                n_run        = '0;
                n_line_start = 1'b1;
            end else if (same) begin
                n_cur        = e_cur;
                n_prev       = e_prev;
                n_run        = run_inc;
                n_line_start = 1'b0;
            end else begin
                n_cur        = i_sample;
                n_prev       = {1'b0, e_cur};
                n_run        = drle_pkg::RUN_W'(1);
                n_line_start = 1'b0;
                n_tail       = i_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur        <= '0;
            r_prev       <= drle_pkg::NONE_MARK;
            r_run        <= '0;
            r_line_start <= 1'b1;
            r_tail       <= 1'b0;
        end else begin
            r_cur        <= n_cur;
            r_prev       <= n_prev;
            r_run        <= n_run;
            r_line_start <= n_line_start;
            r_tail       <= n_tail;
        end
    end

    a_change_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !same && i_last) |=> (r_tail && !o_ready))
        else $error("value change on the last beat did not queue the closing run");

endmodule

// File: src/drle_pack.sv
module drle_pack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_seg_valid,
    input  drle_pkg::t_seg                i_seg,
    output logic                          o_pop,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [7:0]                    o_code_byte,
    output logic                          o_tlast,
    output logic [drle_pkg::LEN_W-1:0]    o_line_length
);

    logic [drle_pkg::BUF_W-1:0]      r_buf;
    logic [drle_pkg::BUF_CNT_W-1:0]  r_cnt;
    logic                            r_flush;
    logic [drle_pkg::LEN_W-1:0]      r_bcount;
    logic                            r_ovalid;
    logic [7:0]                      r_obyte;
    logic                            r_olast;
    logic [drle_pkg::LEN_W-1:0]      r_olen;

    logic                            out_free;
    logic                            have_byte;
    logic                            emit;
    logic                            final_byte;
    logic [drle_pkg::LEN_W-1:0]      bc_inc;
    logic [drle_pkg::BUF_CNT_W-1:0]  shamt;
    logic [drle_pkg::BUF_W-1:0]      load_word;

    assign out_free   = !r_ovalid || i_tready;
    // a full byte, or the padded tail of a line
    assign have_byte  = (r_cnt >= drle_pkg::BUF_CNT_W'(8)) || (r_flush && r_cnt != '0);
    assign emit       = have_byte && out_free;
    assign final_byte = r_flush && (r_cnt <= drle_pkg::BUF_CNT_W'(8));
    assign o_pop      = !have_byte && !r_flush && i_seg_valid;
    assign bc_inc     = (r_bcount == drle_pkg::COUNT_MAX) ? r_bcount : r_bcount + 1'b1;
    assign shamt      = drle_pkg::BUF_CNT_W'(drle_pkg::BUF_W) - r_cnt
                        - drle_pkg::BUF_CNT_W'(i_seg.len);
    assign load_word  = drle_pkg::BUF_W'(i_seg.bits) << shamt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf    <= '0;
            r_cnt    <= '0;
            r_flush  <= 1'b0;
            r_bcount <= drle_pkg::HDR_BYTES;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
            r_olen   <= '0;
            r_obyte  <= '0;
        end else begin
            if (emit) begin
                r_buf    <= r_buf << 8;
                r_cnt    <= final_byte ? '0 : r_cnt - drle_pkg::BUF_CNT_W'(8);
                r_ovalid <= 1'b1;
                r_obyte  <= r_buf[drle_pkg::BUF_W-1 -: 8];
                r_olast  <= final_byte;
                r_olen   <= final_byte ? bc_inc : '0;
                r_bcount <= final_byte ? drle_pkg::HDR_BYTES : bc_inc;
                if (final_byte) begin
                    r_flush <= 1'b0;
                end
            end else begin
                if (i_tready) begin
                    r_ovalid <= 1'b0;
                end
                if (o_pop) begin
                    r_buf   <= r_buf | load_word;
                    r_cnt   <= r_cnt + drle_pkg::BUF_CNT_W'(i_seg.len);
                    r_flush <= i_seg.last;
                end
            end
        end
    end

    assign o_tvalid      = r_ovalid;
    assign o_code_byte   = r_obyte;
    assign o_tlast       = r_olast;
    assign o_line_length = r_olen;

    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= drle_pkg::BUF_CNT_W'(drle_pkg::BUF_FILL_MAX))
        else $error("bit buffer overfilled");

    a_load_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_cnt < drle_pkg::BUF_CNT_W'(8)))
        else $error("code group loaded while a whole byte was pending");

    a_final_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && final_byte) |=> (o_tlast && o_line_length > drle_pkg::HDR_BYTES))
        else $error("line end beat carries no valid length");

endmodule

// File: src/delta_run_length_line_encoder.sv
// Delta run-length line encoder. One sample byte enters per beat; runs of equal bytes are
// coded as 3-bit deltas, literals or long-run escapes and packed MSB-first into code bytes.
// tlast on the input closes the line: the open run is coded, the last byte is zero-padded
// and carries tlast plus the line length (code bytes plus a 4-byte header). The classifier
// takes a beat every cycle while its 4-entry code queue has room, and stalls to queue the
// closing run when the value changes on the last beat. The packer loads a code group only
// while no whole byte is pending and emits code bytes as the output accepts them; a run
// escape with a 24-bit length holds the packer while its bytes are emitted. With the queue
// and packer idle, the first output byte of a closing beat passes through the code queue,
// the bit buffer and the output register after that beat is accepted.
module delta_run_length_line_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] sample
    input  logic        i_s_axis_tlast,   // last_of_line
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] code_byte, [24:8] line_length, [31:25] zero
    output logic        o_m_axis_tlast    // end_of_line
);

    logic                          q_push;
    drle_pkg::t_seg                q_push_seg;
    logic                          q_full;
    logic                          q_valid;
    drle_pkg::t_seg                q_seg;
    logic                          q_pop;
    logic [7:0]                    code_byte;
    logic [drle_pkg::LEN_W-1:0]    line_length;

    drle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_sample (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_push   (q_push),
        .o_seg    (q_push_seg),
        .i_full   (q_full)
    );

    drle_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_seg (q_push_seg),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_seg      (q_seg),
        .i_pop      (q_pop)
    );

    drle_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seg_valid   (q_valid),
        .i_seg         (q_seg),
        .o_pop         (q_pop),
        .o_tvalid      (o_m_axis_tvalid),
        .i_tready      (i_m_axis_tready),
        .o_code_byte   (code_byte),
        .o_tlast       (o_m_axis_tlast),
        .o_line_length (line_length)
    );

    assign o_m_axis_tdata = {7'd0, line_length, code_byte};

endmodule
